>>> src/trilin_pkg.sv
// shared types and constants of the trilinear distance interpolator
package trilin_pkg;

  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned FRAC_W    = 16;
  localparam int unsigned GRAD_W    = 32;
  localparam int unsigned MASK_W    = 8;
  localparam int unsigned CORNERS   = 8;
  // scaled coordinate carries 24 fraction bits, the kept fraction is bits 23..8
  localparam int unsigned SCALE_LSB = 8;
  localparam int unsigned SCALE_W   = FRAC_W + SCALE_LSB;

  localparam logic [CFG_W-1:0] INV_VOXEL_RST = 16'd25600;
  localparam logic [CFG_W-1:0] EXTRAP_RST    = 16'd4096;
  localparam logic [MASK_W-1:0] MASK_NONE    = 8'h00;
  localparam logic [MASK_W-1:0] MASK_FULL    = 8'hFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INV_VOXEL = 2'd0,
    REG_EXTRAP    = 2'd1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    STAT_FULL    = 2'd0,
    STAT_NONE    = 2'd1,
    STAT_PARTIAL = 2'd2
  } status_e;

endpackage

>>> src/trilinear_sdf_interp_gradient.sv
// trilinear distance interpolator with gradient, four-stage pipeline
//
// One query word is taken in every clock cycle: busy_o stays low. The result word
// shows on the outputs once it has passed all four register stages, marked by done_o for
// a single cycle; the receiver cannot hold it off. The four register stages are:
// the three fraction multipliers, the first lerp level (eight lerps along x and y),
// the second lerp level (six lerps), and the final distance lerp together with the
// three gradient scaling multipliers. Configuration writes take effect at once and
// belong in a time when no query is in flight.
module trilinear_sdf_interp_gradient #(
  parameter int unsigned DIST_WIDTH  = 16,
  parameter int unsigned COORD_WIDTH = 32
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [trilin_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [trilin_pkg::CFG_W-1:0]          cfg_wdata_i,
  input  logic                                  start_i,
  output logic                                  busy_o,
  input  logic signed [COORD_WIDTH-1:0]         point_x_i,
  input  logic signed [COORD_WIDTH-1:0]         point_y_i,
  input  logic signed [COORD_WIDTH-1:0]         point_z_i,
  input  logic signed [DIST_WIDTH-1:0]          corner_000_i,
  input  logic signed [DIST_WIDTH-1:0]          corner_100_i,
  input  logic signed [DIST_WIDTH-1:0]          corner_010_i,
  input  logic signed [DIST_WIDTH-1:0]          corner_110_i,
  input  logic signed [DIST_WIDTH-1:0]          corner_001_i,
  input  logic signed [DIST_WIDTH-1:0]          corner_101_i,
  input  logic signed [DIST_WIDTH-1:0]          corner_011_i,
  input  logic signed [DIST_WIDTH-1:0]          corner_111_i,
  input  logic [trilin_pkg::MASK_W-1:0]         present_mask_i,
  output logic                                  done_o,
  output logic signed [DIST_WIDTH-1:0]          dist_value_o,
  output logic signed [trilin_pkg::GRAD_W-1:0]  grad_x_o,
  output logic signed [trilin_pkg::GRAD_W-1:0]  grad_y_o,
  output logic signed [trilin_pkg::GRAD_W-1:0]  grad_z_o,
  output logic [1:0]                            status_o
);
  import trilin_pkg::*;

  localparam int unsigned DW = DIST_WIDTH;
  localparam int unsigned PW = DW + FRAC_W + 2;        // diff times 17-bit operand
  localparam int unsigned SW = (PW > GRAD_W + 1) ? PW : GRAD_W + 1;
  localparam logic signed [SW-1:0] GRAD_MAX = SW'(34'sh0_7FFF_FFFF);
  localparam logic signed [SW-1:0] GRAD_MIN = SW'(-34'sh0_8000_0000);
  localparam logic signed [PW-1:0] LERP_RND = PW'(1 << (FRAC_W - 1));
  localparam logic signed [SW-1:0] GRAD_RND = SW'(1 << (SCALE_LSB - 1));

  // a + floor(((b - a) * f + half) / 2^16), always between a and b
  function automatic logic signed [DW-1:0] lerp(input logic signed [DW-1:0] a,
                                                input logic signed [DW-1:0] b,
                                                input logic [FRAC_W-1:0]    f);
    logic signed [DW:0]   diff;
    logic signed [PW-1:0] prod;
    logic signed [PW-1:0] shifted;
    diff    = (DW+1)'(b) - (DW+1)'(a);
    prod    = PW'(diff * $signed({1'b0, f})) + LERP_RND;
    shifted = prod >>> FRAC_W;
    return a + DW'(shifted);
  endfunction

  // low fraction bits of point times inverse voxel size
  function automatic logic [FRAC_W-1:0] frac_of(input logic [SCALE_W-1:0] p,
                                                input logic [CFG_W-1:0]   s);
    logic [SCALE_W+CFG_W-1:0] prod;
    prod = (SCALE_W+CFG_W)'(p) * (SCALE_W+CFG_W)'(s);
    return prod[SCALE_W-1:SCALE_LSB];
  endfunction

  function automatic logic signed [GRAD_W-1:0] grad_of(input logic [CFG_W-1:0]      s,
                                                       input logic signed [DW-1:0] f1,
                                                       input logic signed [DW-1:0] f0);
    logic signed [DW:0]   diff;
    logic signed [SW-1:0] prod;
    logic signed [SW-1:0] g;
    diff = (DW+1)'(f1) - (DW+1)'(f0);
    prod = SW'(diff * $signed({1'b0, s})) + GRAD_RND;
    g    = prod >>> SCALE_LSB;
    if (g > GRAD_MAX) g = GRAD_MAX;
    if (g < GRAD_MIN) g = GRAD_MIN;
    return GRAD_W'(g);
  endfunction

  // configuration registers
  logic [CFG_W-1:0]        inv_voxel_q;
  logic signed [CFG_W-1:0] extrap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_voxel_q <= INV_VOXEL_RST;
      extrap_q    <= EXTRAP_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_INV_VOXEL: inv_voxel_q <= cfg_wdata_i;
        REG_EXTRAP:    extrap_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign busy_o = 1'b0;

  logic accept;
  assign accept = start_i && !busy_o;

  // valid bits travel with the words
  logic v1_q, v2_q, v3_q, v4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= accept;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  // stage 1: fractions and status
  logic [FRAC_W-1:0]      s1_fx_q, s1_fy_q, s1_fz_q;
  logic signed [DW-1:0]   s1_d_q [CORNERS];
  status_e                s1_stat_q, s1_stat_d;

  always_comb begin
    if (present_mask_i == MASK_NONE) begin
      s1_stat_d = STAT_NONE;
    end else if (present_mask_i == MASK_FULL) begin
      s1_stat_d = STAT_FULL;
    end else begin
      s1_stat_d = STAT_PARTIAL;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_fx_q   <= frac_of(SCALE_W'(point_x_i), inv_voxel_q);
      s1_fy_q   <= frac_of(SCALE_W'(point_y_i), inv_voxel_q);
      s1_fz_q   <= frac_of(SCALE_W'(point_z_i), inv_voxel_q);
      s1_d_q[0] <= corner_000_i;
      s1_d_q[1] <= corner_100_i;
      s1_d_q[2] <= corner_010_i;
      s1_d_q[3] <= corner_110_i;
      s1_d_q[4] <= corner_001_i;
      s1_d_q[5] <= corner_101_i;
      s1_d_q[6] <= corner_011_i;
      s1_d_q[7] <= corner_111_i;
      s1_stat_q <= s1_stat_d;
    end
  end

  // stage 2: edge lerps along x and along y
  logic [FRAC_W-1:0]    s2_fy_q, s2_fz_q;
  logic signed [DW-1:0] s2_d01_q, s2_d23_q, s2_d45_q, s2_d67_q;
  logic signed [DW-1:0] s2_d02_q, s2_d13_q, s2_d46_q, s2_d57_q;
  status_e              s2_stat_q;

  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      s2_fy_q   <= s1_fy_q;
      s2_fz_q   <= s1_fz_q;
      s2_d01_q  <= lerp(s1_d_q[0], s1_d_q[1], s1_fx_q);
      s2_d23_q  <= lerp(s1_d_q[2], s1_d_q[3], s1_fx_q);
      s2_d45_q  <= lerp(s1_d_q[4], s1_d_q[5], s1_fx_q);
      s2_d67_q  <= lerp(s1_d_q[6], s1_d_q[7], s1_fx_q);
      s2_d02_q  <= lerp(s1_d_q[0], s1_d_q[2], s1_fy_q);
      s2_d13_q  <= lerp(s1_d_q[1], s1_d_q[3], s1_fy_q);
      s2_d46_q  <= lerp(s1_d_q[4], s1_d_q[6], s1_fy_q);
      s2_d57_q  <= lerp(s1_d_q[5], s1_d_q[7], s1_fy_q);
      s2_stat_q <= s1_stat_q;
    end
  end

  // stage 3: face lerps, two opposite faces per axis
  logic [FRAC_W-1:0]    s3_fz_q;
  logic signed [DW-1:0] s3_x1_q, s3_x0_q, s3_y1_q, s3_y0_q, s3_z1_q, s3_z0_q;
  status_e              s3_stat_q;

  always_ff @(posedge clk_i) begin
    if (v2_q) begin
      s3_fz_q   <= s2_fz_q;
      s3_x1_q   <= lerp(s2_d13_q, s2_d57_q, s2_fz_q);
      s3_x0_q   <= lerp(s2_d02_q, s2_d46_q, s2_fz_q);
      s3_y1_q   <= lerp(s2_d23_q, s2_d67_q, s2_fz_q);
      s3_y0_q   <= lerp(s2_d01_q, s2_d45_q, s2_fz_q);
      s3_z1_q   <= lerp(s2_d45_q, s2_d67_q, s2_fy_q);
      s3_z0_q   <= lerp(s2_d01_q, s2_d23_q, s2_fy_q);
      s3_stat_q <= s2_stat_q;
    end
  end

  // stage 4: final distance lerp, gradient scaling and result select
  logic signed [DW-1:0]     dist_d;
  logic signed [GRAD_W-1:0] gx_d, gy_d, gz_d;

  always_comb begin
    dist_d = '0;
    gx_d   = '0;
    gy_d   = '0;
    gz_d   = '0;
    unique case (s3_stat_q)
      STAT_FULL: begin
        // z faces are the lower and upper bilinear planes
        dist_d = lerp(s3_z0_q, s3_z1_q, s3_fz_q);
        gx_d   = grad_of(inv_voxel_q, s3_x1_q, s3_x0_q);
        gy_d   = grad_of(inv_voxel_q, s3_y1_q, s3_y0_q);
        gz_d   = grad_of(inv_voxel_q, s3_z1_q, s3_z0_q);
      end
      STAT_NONE:    dist_d = DW'(extrap_q);
      STAT_PARTIAL: dist_d = '0;
      default:      dist_d = '0;
    endcase
  end

  logic signed [DW-1:0]     dist_q;
  logic signed [GRAD_W-1:0] gx_q, gy_q, gz_q;
  status_e                  stat_q;

  always_ff @(posedge clk_i) begin
    if (v3_q) begin
      dist_q <= dist_d;
      gx_q   <= gx_d;
      gy_q   <= gy_d;
      gz_q   <= gz_d;
      stat_q <= s3_stat_q;
    end
  end

  assign done_o       = v4_q;
  assign dist_value_o = dist_q;
  assign grad_x_o     = gx_q;
  assign grad_y_o     = gy_q;
  assign grad_z_o     = gz_q;
  assign status_o     = stat_q;

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##4 done_o)
    else $error("accepted query did not complete after four cycles");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, 4))
    else $error("result word without a query four cycles earlier");

  a_grad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o != STAT_FULL) |->
      (grad_x_o == '0) && (grad_y_o == '0) && (grad_z_o == '0))
    else $error("gradient not zero for a query without all corners");

  a_extrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o == STAT_NONE) |-> dist_value_o == DW'(extrap_q))
    else $error("empty query did not return the extrapolation value");

  a_partial: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o == STAT_PARTIAL) |-> dist_value_o == '0)
    else $error("partial query returned a nonzero distance");
`endif

endmodule

>>> dv/tb.sv
// self-checking testbench for the trilinear distance interpolator with gradient
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import trilin_pkg::*;

  localparam int unsigned DIST_W       = 16;
  localparam int unsigned COORD_W      = 32;
  localparam int unsigned PIPE_DEPTH   = 4;
  localparam int unsigned DRAIN_CYCLES = 200;
  localparam int          PHASE_ITEMS  = 325;
  localparam int          PHASES       = 6;
  localparam int unsigned TIMEOUT_NS   = 1_000_000;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;
  localparam longint GRAD_MAX = 64'sd2147483647;
  localparam longint GRAD_MIN = -64'sd2147483648;

  typedef struct packed {
    logic [COORD_W-1:0]             px;
    logic [COORD_W-1:0]             py;
    logic [COORD_W-1:0]             pz;
    logic [CORNERS-1:0][DIST_W-1:0] corners;
    logic [MASK_W-1:0]              mask;
  } query_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic [GRAD_W-1:0] gx;
    logic [GRAD_W-1:0] gy;
    logic [GRAD_W-1:0] gz;
    status_e           status;
  } dist_word_t;

  class interp_checker;
    logic [CFG_W-1:0] inv_scale;
    logic [CFG_W-1:0] extrap_dist;
    dist_word_t       pending_words[$];
    int unsigned      faults;
    int unsigned      n_full;
    int unsigned      n_none;
    int unsigned      n_partial;

    function new();
      inv_scale   = INV_VOXEL_RST;
      extrap_dist = EXTRAP_RST;
      faults      = 0;
      n_full      = 0;
      n_none      = 0;
      n_partial   = 0;
    endfunction

    function void note_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_INV_VOXEL: inv_scale = data;
        REG_EXTRAP:    extrap_dist = data;
        default: ;  // spare indexes are dropped
      endcase
    endfunction

    // bits 23..8 of point * inv_scale, always in [0,1)
    function longint fraction(logic [COORD_W-1:0] coord);
      longint scaled;
      scaled = longint'($signed(coord)) * longint'(inv_scale);
      return (scaled >>> SCALE_LSB) & 64'hFFFF;
    endfunction

    // round half up, arithmetic shift gives the floor
    function longint blend(longint a, longint b, longint f);
      return a + (((b - a) * f + 32768) >>> 16);
    endfunction

    function logic [GRAD_W-1:0] slope(longint hi, longint lo);
      longint g;
      g = (longint'(inv_scale) * (hi - lo) + 128) >>> 8;
      if (g > GRAD_MAX) g = GRAD_MAX;
      if (g < GRAD_MIN) g = GRAD_MIN;
      return g[GRAD_W-1:0];
    endfunction

    function dist_word_t predict(query_t q);
      dist_word_t w;
      longint d[CORNERS];
      longint fx, fy, fz;
      longint x_y0z0, x_y1z0, x_y0z1, x_y1z1;
      longint y_x0z0, y_x1z0, y_x0z1, y_x1z1;
      longint mixed;
      w = '0;
      if (q.mask == MASK_NONE) begin
        w.distance = extrap_dist;
        w.status   = STAT_NONE;
        return w;
      end
      if (q.mask != MASK_FULL) begin
        w.status = STAT_PARTIAL;
        return w;
      end
      for (int k = 0; k < CORNERS; k++) d[k] = longint'($signed(q.corners[k]));
      fx = fraction(q.px);
      fy = fraction(q.py);
      fz = fraction(q.pz);
      x_y0z0 = blend(d[0], d[1], fx);
      x_y1z0 = blend(d[2], d[3], fx);
      x_y0z1 = blend(d[4], d[5], fx);
      x_y1z1 = blend(d[6], d[7], fx);
      y_x0z0 = blend(d[0], d[2], fy);
      y_x1z0 = blend(d[1], d[3], fy);
      y_x0z1 = blend(d[4], d[6], fy);
      y_x1z1 = blend(d[5], d[7], fy);
      w.gx = slope(blend(y_x1z0, y_x1z1, fz), blend(y_x0z0, y_x0z1, fz));
      w.gy = slope(blend(x_y1z0, x_y1z1, fz), blend(x_y0z0, x_y0z1, fz));
      w.gz = slope(blend(x_y0z1, x_y1z1, fy), blend(x_y0z0, x_y1z0, fy));
      mixed = blend(blend(x_y0z0, x_y1z0, fy), blend(x_y0z1, x_y1z1, fy), fz);
      w.distance = mixed[DIST_W-1:0];
      w.status   = STAT_FULL;
      return w;
    endfunction

    function void note_query(query_t q);
      pending_words.insert(pending_words.size(), predict(q));
    endfunction

    function int unsigned pending();
      return pending_words.size();
    endfunction

    function void flag(string msg);
      if (faults < 10) $display("mismatch at %0t: %s", $time, msg);
      faults++;
    endfunction

    function void compare(string what, logic [GRAD_W-1:0] want, logic [GRAD_W-1:0] seen);
      if (want !== seen) flag($sformatf("%s expected %08h got %08h", what, want, seen));
    endfunction

    function void check_word(dist_word_t seen);
      dist_word_t want;
      if (pending_words.size() == 0) begin
        flag("result word with no query in flight");
        return;
      end
      want = pending_words.pop_front();
      case (want.status)
        STAT_FULL: n_full++;
        STAT_NONE: n_none++;
        default:   n_partial++;
      endcase
      compare("dist_value", GRAD_W'(want.distance), GRAD_W'(seen.distance));
      compare("grad_x", want.gx, seen.gx);
      compare("grad_y", want.gy, seen.gy);
      compare("grad_z", want.gz, seen.gz);
      compare("status", GRAD_W'(want.status), GRAD_W'(seen.status));
    endfunction
  endclass

  logic                             clk_i          = 1'b0;
  logic                             rst_ni         = 1'b0;
  logic                             cfg_we_i       = 1'b0;
  logic [CFG_IDX_W-1:0]             cfg_idx_i      = '0;
  logic [CFG_W-1:0]                 cfg_wdata_i    = '0;
  logic                             start_i        = 1'b0;
  logic                             busy_o;
  logic signed [COORD_W-1:0]        point_x_i      = '0;
  logic signed [COORD_W-1:0]        point_y_i      = '0;
  logic signed [COORD_W-1:0]        point_z_i      = '0;
  logic signed [DIST_W-1:0]         corner_000_i   = '0;
  logic signed [DIST_W-1:0]         corner_100_i   = '0;
  logic signed [DIST_W-1:0]         corner_010_i   = '0;
  logic signed [DIST_W-1:0]         corner_110_i   = '0;
  logic signed [DIST_W-1:0]         corner_001_i   = '0;
  logic signed [DIST_W-1:0]         corner_101_i   = '0;
  logic signed [DIST_W-1:0]         corner_011_i   = '0;
  logic signed [DIST_W-1:0]         corner_111_i   = '0;
  logic [MASK_W-1:0]                present_mask_i = '0;
  logic                             done_o;
  logic signed [DIST_W-1:0]         dist_value_o;
  logic signed [GRAD_W-1:0]         grad_x_o;
  logic signed [GRAD_W-1:0]         grad_y_o;
  logic signed [GRAD_W-1:0]         grad_z_o;
  logic [1:0]                       status_o;

  interp_checker board = new();
  int unsigned   settings_used = 1;

  trilinear_sdf_interp_gradient #(
    .DIST_WIDTH (DIST_W),
    .COORD_WIDTH(COORD_W)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .point_x_i     (point_x_i),
    .point_y_i     (point_y_i),
    .point_z_i     (point_z_i),
    .corner_000_i  (corner_000_i),
    .corner_100_i  (corner_100_i),
    .corner_010_i  (corner_010_i),
    .corner_110_i  (corner_110_i),
    .corner_001_i  (corner_001_i),
    .corner_101_i  (corner_101_i),
    .corner_011_i  (corner_011_i),
    .corner_111_i  (corner_111_i),
    .present_mask_i(present_mask_i),
    .done_o        (done_o),
    .dist_value_o  (dist_value_o),
    .grad_x_o      (grad_x_o),
    .grad_y_o      (grad_y_o),
    .grad_z_o      (grad_z_o),
    .status_o      (status_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // result words are sampled mid-cycle, away from the driving edge
  always @(negedge clk_i) begin : watch
    dist_word_t seen;
    if (rst_ni && done_o) begin
      seen.distance = dist_value_o;
      seen.gx       = grad_x_o;
      seen.gy       = grad_y_o;
      seen.gz       = grad_z_o;
      seen.status   = status_e'(status_o);
      board.check_word(seen);
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(11, 30);
  endfunction

  function automatic logic [COORD_W-1:0] pick_coord();
    if ($urandom_range(0, 3) != 0) return COORD_W'($urandom);
    // near the origin, within 2^20 either way
    return COORD_W'($urandom_range(0, 32'h001F_FFFF)) - 32'h0010_0000;
  endfunction

  function automatic query_t make_query(logic [COORD_W-1:0] px, logic [COORD_W-1:0] py,
                                        logic [COORD_W-1:0] pz,
                                        logic [CORNERS*DIST_W-1:0] corners,
                                        logic [MASK_W-1:0] mask);
    query_t q;
    q.px      = px;
    q.py      = py;
    q.pz      = pz;
    q.corners = corners;
    q.mask    = mask;
    return q;
  endfunction

  function automatic query_t random_query();
    query_t            q;
    int unsigned       style;
    logic [DIST_W-1:0] base;
    q.px  = pick_coord();
    q.py  = pick_coord();
    q.pz  = pick_coord();
    style = $urandom_range(0, 9);
    base  = DIST_W'($urandom);
    for (int k = 0; k < CORNERS; k++) begin
      if (style == 0) q.corners[k] = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
      else if (style < 4) q.corners[k] = base + DIST_W'($urandom_range(0, 2047)) - 16'd1024;
      else q.corners[k] = DIST_W'($urandom);
    end
    style = $urandom_range(0, 99);
    if (style < 70) q.mask = MASK_FULL;
    else if (style < 80) q.mask = MASK_NONE;
    else begin
      do q.mask = MASK_W'($urandom); while (q.mask == MASK_NONE || q.mask == MASK_FULL);
    end
    return q;
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    board.note_write(idx, data);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // holds the query word until it is taken; start stays up when gap is zero
  task automatic send_query(query_t q, int unsigned gap);
    bit taken;
    start_i        <= 1'b1;
    point_x_i      <= q.px;
    point_y_i      <= q.py;
    point_z_i      <= q.pz;
    corner_000_i   <= q.corners[0];
    corner_100_i   <= q.corners[1];
    corner_010_i   <= q.corners[2];
    corner_110_i   <= q.corners[3];
    corner_001_i   <= q.corners[4];
    corner_101_i   <= q.corners[5];
    corner_011_i   <= q.corners[6];
    corner_111_i   <= q.corners[7];
    present_mask_i <= q.mask;
    do begin
      @(negedge clk_i);
      taken = !busy_o;
      if (taken) board.note_query(q);
      @(posedge clk_i);
    end while (!taken);
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic settle();
    int unsigned waited;
    waited  = 0;
    start_i <= 1'b0;
    while (board.pending() != 0 && waited < DRAIN_CYCLES) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (PIPE_DEPTH + 2) @(posedge clk_i);
  endtask

  initial begin : stimulus
    int          burst_left;
    logic [CFG_W-1:0] inv_set[PHASES];
    logic [CFG_W-1:0] extrap_set[PHASES];
    inv_set    = '{INV_VOXEL_RST, 16'hFFFF, 16'h0001, 16'h0000, 16'h0100, 16'h0000};
    extrap_set = '{EXTRAP_RST, 16'h8000, 16'h7FFF, 16'h0000, 16'h0000, 16'h0000};
    inv_set[5]    = CFG_W'($urandom_range(1, 65535));
    extrap_set[4] = CFG_W'($urandom);
    extrap_set[5] = CFG_W'($urandom);
    burst_left    = 0;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed words at reset settings
    send_query(make_query(0, 0, 0, {8{16'h1234}}, MASK_NONE), pick_gap());
    send_query(make_query(32'h7FFF_FFFF, 32'h8000_0000, 0, {8{16'h7FFF}}, 8'h01), pick_gap());
    send_query(make_query(0, 0, 0, {8{16'h8000}}, 8'h80), pick_gap());
    send_query(make_query(32'hFFFF_FFFF, 0, 32'h7FFF_FFFF, {8{16'h7FFF}}, 8'hFE), pick_gap());
    send_query(make_query(0, 32'h0001_0000, 0, {8{16'h8000}}, 8'h7F), pick_gap());
    send_query(make_query($urandom, $urandom, $urandom, {$urandom, $urandom, $urandom, $urandom},
                          8'h55), pick_gap());
    send_query(make_query(0, 0, 0, {8{16'h7FFF}}, MASK_FULL), pick_gap());
    send_query(make_query(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, {8{16'h8000}}, MASK_FULL),
               pick_gap());
    // opposite faces at the extremes, one axis at a time
    send_query(make_query(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, {4{16'h7FFF, 16'h8000}},
                          MASK_FULL), pick_gap());
    send_query(make_query(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, {4{16'h8000, 16'h7FFF}},
                          MASK_FULL), pick_gap());
    send_query(make_query(32'h0000_028F, 32'h0000_028F, 32'h0000_028F,
                          {2{16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000}}, MASK_FULL), pick_gap());
    settle();
    send_query(make_query(32'hFFFF_FD71, 32'hFFFF_FD71, 32'hFFFF_FD71,
                          {{4{16'h7FFF}}, {4{16'h8000}}}, MASK_FULL), pick_gap());
    send_query(make_query(32'h0000_8000, 32'h0000_4000, 32'h0000_C000,
                          {{4{16'h8000}}, {4{16'h7FFF}}}, MASK_FULL), pick_gap());
    send_query(make_query(32'h0000_8000, 32'hFFFF_8000, 32'h0012_3456,
                          {16'h7000, 16'h6000, 16'h5000, 16'h4000,
                           16'h3000, 16'h2000, 16'h1000, 16'h0000}, MASK_FULL), 0);
    send_query(make_query(32'h1234_5678, 32'h5555_5555, 32'hAAAA_AAAA,
                          {16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000,
                           16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF}, MASK_FULL), 0);
    send_query(make_query(32'hAAAA_AAAA, 32'h5555_5555, 32'hFEDC_BA98, {8{16'h0000}}, MASK_FULL),
               pick_gap());
    send_query(make_query(32'h7FFF_FFFF, 0, 32'h8000_0000, {8{16'h5A5A}}, MASK_NONE), pick_gap());

    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase != 0) begin
        settle();
        write_reg(REG_INV_VOXEL, inv_set[phase]);
        write_reg(REG_EXTRAP, extrap_set[phase]);
        // writes to unused indexes must leave both registers alone
        if (phase == 3 || phase == 5) begin
          write_reg(REG_SPARE_LO, CFG_W'($urandom));
          write_reg(REG_SPARE_HI, CFG_W'($urandom));
        end
        settings_used++;
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (burst_left == 0 && $urandom_range(0, 49) == 0) burst_left = 40;
        if ($urandom_range(0, 149) == 0) settle();
        send_query(random_query(), (burst_left != 0) ? 0 : pick_gap());
        if (burst_left != 0) burst_left--;
      end
    end

    settle();
    if (board.pending() != 0) begin
      $display("%0d result words never arrived", board.pending());
      board.faults += board.pending();
    end
    $display("checked %0d result words: %0d with all corners, %0d empty, %0d partial",
             board.n_full + board.n_none + board.n_partial, board.n_full, board.n_none,
             board.n_partial);
    $display("used %0d register settings, inverse voxel size from zero to full scale",
             settings_used);
    if (board.faults == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("timeout: run did not complete");
    $display("*** FAILED ***");
    $finish;
  end

endmodule
